@@ rtl/lpbt_pkg.sv @@
`timescale 1ns / 1ps
package lpbt_pkg;

   localparam int POOL_SLOTS_DEF = 16;
   localparam int MAX_RESULTS    = 16;

   localparam int KIND_W   = 2;
   localparam int PAGE_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 5;
   localparam int DCNT_W   = 5;
   localparam int WORD_W   = PAGE_W + 1;
   localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

   localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(16);

   localparam logic [KIND_W-1:0] KIND_READ      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSH_ALL = 2'd3;

   localparam logic [STATUS_W-1:0] STS_HIT       = 3'd0;
   localparam logic [STATUS_W-1:0] STS_INSERTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_DIRTY = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ABSENT    = 3'd3;
   localparam logic [STATUS_W-1:0] STS_DIRTY     = 3'd4;
   localparam logic [STATUS_W-1:0] STS_BAD_ID    = 3'd5;

   typedef struct packed {
      logic              dirty;
      logic [PAGE_W-1:0] page;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                writeback;
      logic [PAGE_W-1:0]   wb_page;
      logic                full_res;
      logic [DCNT_W-1:0]   dirty_count;
      logic                last;
   } rsp_type;

endpackage

@@ rtl/lru_page_buffer_tracker.sv @@
// A touch or a flush walks the list from slot 0 until it finds the page; a miss walks all the
// filled slots; a mark-dirty searches and then walks again, shifting; flush-all walks the filled
// slots. Result-side stalls add to each. One transaction at a time, set by the single
// RAM read port. A pool shrink counts the dropped slots at one per cycle once the block is idle,
// with req_ready low. Reset: synchronous, empties the list by zeroing the fill count (RAM contents
// are not cleared), clears the dirty count and sets the pool size to 16.
`timescale 1ns / 1ps
module lru_page_buffer_tracker #(
   parameter int POOL_SLOTS = lpbt_pkg::POOL_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lpbt_pkg::KIND_W-1:0]   req_kind,
   input  logic [lpbt_pkg::PAGE_W-1:0]   req_page_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lpbt_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_writeback,
   output logic [lpbt_pkg::PAGE_W-1:0]   rsp_wb_page,
   output logic                          rsp_full_res,
   output logic [lpbt_pkg::DCNT_W-1:0]   rsp_dirty_count,
   output logic                          rsp_last,
   input  logic                          csr_wr_en,
   input  logic [lpbt_pkg::CFG_W-1:0]    csr_wr_data
);

   localparam int AW = $clog2(POOL_SLOTS);
   localparam int CW = $clog2(POOL_SLOTS + 1);
   localparam int MW = (CW > lpbt_pkg::CFG_W) ? CW : lpbt_pkg::CFG_W;
   localparam int DW = lpbt_pkg::DCNT_W;
   localparam int NW = lpbt_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WALK  = 3'd1;
   localparam logic [2:0] ST_TAIL  = 3'd2;
   localparam logic [2:0] ST_FRONT = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   function automatic logic [CW-1:0] act_size(input logic [lpbt_pkg::CFG_W-1:0] v);
      logic [MW-1:0] ve;
      ve = MW'(v);
      if (ve == '0) begin
         return CW'(1);
      end
      if (ve > MW'(POOL_SLOTS)) begin
         return CW'(POOL_SLOTS);
      end
      return CW'(ve);
   endfunction

   logic [2:0]                    state_ff, state_in;
   logic [lpbt_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [lpbt_pkg::PAGE_W-1:0]   page_ff, page_in;
   logic                          bad_ff, bad_in;
   logic                          shift_ff, shift_in;
   logic [CW-1:0]                 rp_ff, rp_in;
   logic                          dv_ff, dv_in;
   logic [AW-1:0]                 di_ff, di_in;
   lpbt_pkg::entry_type           carry_ff, carry_in;
   logic                          front_dirty_ff, front_dirty_in;
   logic                          front_wb_ff, front_wb_in;
   logic [lpbt_pkg::STATUS_W-1:0] front_status_ff, front_status_in;
   logic [DW-1:0]                 dirty_ff, dirty_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic [lpbt_pkg::CFG_W-1:0]    pool_ff, pool_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW-1:0]                 lo_ff, lo_in;
   logic                          sw_dv_ff, sw_dv_in;
   logic [NW-1:0]                 cnt_ff, cnt_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [lpbt_pkg::PAGE_W-1:0]   pend_page_ff, pend_page_in;
   logic [DW-1:0]                 pend_dirty_ff, pend_dirty_in;
   lpbt_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   lpbt_pkg::entry_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   lpbt_pkg::entry_type rd_word;

   logic [CW-1:0] n_act;
   logic [CW-1:0] n_new;
   logic [CW-1:0] rem_dec;
   logic          sweeping;
   logic          out_free;
   logic          shifting;
   logic          match;
   logic          last_slot;
   logic          consume;
   logic          leave;
   logic          emit;
   logic [DW-1:0] dirty_dec;

   lpbt_ram #(
      .WIDTH (lpbt_pkg::WORD_W),
      .DEPTH (POOL_SLOTS)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign n_act     = act_size(pool_ff);
   assign n_new     = act_size(csr_wr_data);
   assign rem_dec   = rem_ff - CW'(1);
   assign sweeping  = (rem_ff > lo_ff) || sw_dv_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign shifting  = (kind_ff == lpbt_pkg::KIND_READ) || shift_ff;
   assign match     = (rd_word.page == page_ff);
   assign last_slot = ((CW'(di_ff) + CW'(1)) == fill_ff);
   assign dirty_dec = (dirty_ff != '0) ? (dirty_ff - DW'(1)) : dirty_ff;
   assign req_ready = (state_ff == ST_IDLE) && !sweeping && !csr_wr_en;

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      page_in         = page_ff;
      bad_in          = bad_ff;
      shift_in        = shift_ff;
      rp_in           = rp_ff;
      dv_in           = dv_ff;
      di_in           = di_ff;
      carry_in        = carry_ff;
      front_dirty_in  = front_dirty_ff;
      front_wb_in     = front_wb_ff;
      front_status_in = front_status_ff;
      dirty_in        = dirty_ff;
      fill_in         = fill_ff;
      pool_in         = pool_ff;
      rem_in          = rem_ff;
      lo_in           = lo_ff;
      sw_dv_in        = 1'b0;
      cnt_in          = cnt_ff;
      pend_valid_in   = pend_valid_ff;
      pend_page_in    = pend_page_ff;
      pend_dirty_in   = pend_dirty_ff;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      consume         = 1'b0;
      leave           = 1'b0;
      emit            = 1'b0;
      rsp_in             = rsp_ff;
      rsp_in.status      = lpbt_pkg::STS_HIT;
      rsp_in.writeback   = 1'b0;
      rsp_in.wb_page     = '0;
      rsp_in.full_res    = (fill_ff == n_act);
      rsp_in.dirty_count = dirty_ff;
      rsp_in.last        = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               kind_in       = req_kind;
               page_in       = req_page_id;
               bad_in        = (req_kind != lpbt_pkg::KIND_FLUSH_ALL) && (req_page_id == '0);
               shift_in      = 1'b0;
               rp_in         = '0;
               dv_in         = 1'b0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
               if (bad_in) begin
                  state_in = ST_FIN;
               end else if (fill_ff == '0) begin
                  state_in = (req_kind == lpbt_pkg::KIND_READ) ? ST_TAIL : ST_FIN;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (dv_ff) begin
               if (shifting) begin
                  // move each entry down one slot; the hit or the new page lands at the front
                  consume = 1'b1;
                  if (di_ff != '0) begin
                     wr_en   = 1'b1;
                     wr_addr = di_ff;
                     wr_data = carry_ff;
                  end
                  if (match) begin
                     front_dirty_in  = (kind_ff == lpbt_pkg::KIND_MARK) ? 1'b1 : rd_word.dirty;
                     front_status_in = lpbt_pkg::STS_HIT;
                     front_wb_in     = 1'b0;
                     state_in        = ST_FRONT;
                     leave           = 1'b1;
                  end else begin
                     carry_in = rd_word;
                     if (last_slot) begin
                        state_in = (kind_ff == lpbt_pkg::KIND_READ) ? ST_TAIL : ST_FIN;
                        leave    = 1'b1;
                     end
                  end
               end else if (kind_ff == lpbt_pkg::KIND_MARK) begin
                  if (match) begin
                     if (rd_word.dirty) begin
                        if (out_free) begin
                           consume       = 1'b1;
                           emit          = 1'b1;
                           rsp_in.status = lpbt_pkg::STS_DIRTY;
                           state_in      = ST_IDLE;
                           leave         = 1'b1;
                        end
                     end else begin
                        // found clean: walk again, this time shifting
                        consume  = 1'b1;
                        shift_in = 1'b1;
                        rp_in    = '0;
                        leave    = 1'b1;
                     end
                  end else begin
                     consume = 1'b1;
                     if (last_slot) begin
                        state_in = ST_FIN;
                        leave    = 1'b1;
                     end
                  end
               end else if (kind_ff == lpbt_pkg::KIND_FLUSH) begin
                  if (match) begin
                     if (out_free) begin
                        consume  = 1'b1;
                        emit     = 1'b1;
                        state_in = ST_IDLE;
                        leave    = 1'b1;
                        if (rd_word.dirty) begin
                           wr_en              = 1'b1;
                           wr_addr            = di_ff;
                           wr_data.dirty      = 1'b0;
                           wr_data.page       = rd_word.page;
                           dirty_in           = dirty_dec;
                           rsp_in.writeback   = 1'b1;
                           rsp_in.wb_page     = page_ff;
                           rsp_in.dirty_count = dirty_dec;
                        end else begin
                           rsp_in.status = lpbt_pkg::STS_NOT_DIRTY;
                        end
                     end
                  end else begin
                     consume = 1'b1;
                     if (last_slot) begin
                        state_in = ST_FIN;
                        leave    = 1'b1;
                     end
                  end
               end else begin
                  // flush all: hold each write-back one step so the final one can carry last
                  if (rd_word.dirty) begin
                     if (!pend_valid_ff || out_free) begin
                        consume = 1'b1;
                        if (pend_valid_ff) begin
                           emit               = 1'b1;
                           rsp_in.writeback   = 1'b1;
                           rsp_in.wb_page     = pend_page_ff;
                           rsp_in.dirty_count = pend_dirty_ff;
                           rsp_in.last        = 1'b0;
                        end
                        wr_en         = 1'b1;
                        wr_addr       = di_ff;
                        wr_data.dirty = 1'b0;
                        wr_data.page  = rd_word.page;
                        dirty_in      = dirty_dec;
                        pend_valid_in = 1'b1;
                        pend_page_in  = rd_word.page;
                        pend_dirty_in = dirty_dec;
                        cnt_in        = cnt_ff + NW'(1);
                        if (last_slot || (cnt_in == NW'(lpbt_pkg::MAX_RESULTS))) begin
                           state_in = ST_FIN;
                           leave    = 1'b1;
                        end
                     end
                  end else begin
                     consume = 1'b1;
                     if (last_slot) begin
                        state_in = ST_FIN;
                        leave    = 1'b1;
                     end
                  end
               end
            end

            if ((!dv_ff || consume) && !leave) begin
               if (rp_ff < fill_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = rp_ff[AW-1:0];
                  rp_in   = rp_ff + CW'(1);
                  di_in   = rp_ff[AW-1:0];
                  dv_in   = 1'b1;
               end else begin
                  dv_in = 1'b0;
               end
            end
            if (leave) begin
               dv_in = 1'b0;
            end
         end

         ST_TAIL: begin
            front_dirty_in  = 1'b0;
            front_status_in = lpbt_pkg::STS_INSERTED;
            if (fill_ff < n_act) begin
               wr_en       = 1'b1;
               wr_addr     = fill_ff[AW-1:0];
               wr_data     = carry_ff;
               fill_in     = fill_ff + CW'(1);
               front_wb_in = 1'b0;
            end else begin
               // tail pushed out; report it if dirty
               front_wb_in = carry_ff.dirty;
            end
            state_in = ST_FRONT;
         end

         ST_FRONT: begin
            if (out_free) begin
               wr_en         = 1'b1;
               wr_addr       = '0;
               wr_data.dirty = front_dirty_ff;
               wr_data.page  = page_ff;
               if (kind_ff == lpbt_pkg::KIND_MARK) begin
                  dirty_in = dirty_ff + DW'(1);
               end else if (front_wb_ff) begin
                  dirty_in = dirty_dec;
               end
               emit               = 1'b1;
               rsp_in.status      = front_status_ff;
               rsp_in.writeback   = front_wb_ff;
               rsp_in.wb_page     = front_wb_ff ? carry_ff.page : '0;
               rsp_in.dirty_count = dirty_in;
               state_in           = ST_IDLE;
            end
         end

         ST_FIN: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (bad_ff) begin
                  rsp_in.status = lpbt_pkg::STS_BAD_ID;
               end else if (kind_ff == lpbt_pkg::KIND_FLUSH_ALL) begin
                  if (pend_valid_ff) begin
                     rsp_in.writeback   = 1'b1;
                     rsp_in.wb_page     = pend_page_ff;
                     rsp_in.dirty_count = pend_dirty_ff;
                  end else begin
                     rsp_in.status = lpbt_pkg::STS_NOT_DIRTY;
                  end
                  pend_valid_in = 1'b0;
               end else begin
                  rsp_in.status = lpbt_pkg::STS_ABSENT;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // count dirty pages in slots dropped by a pool shrink, top slot first
      if (state_ff == ST_IDLE && rem_ff > lo_ff) begin
         rd_en    = 1'b1;
         rd_addr  = rem_dec[AW-1:0];
         rem_in   = rem_dec;
         sw_dv_in = 1'b1;
      end
      if (sw_dv_ff && rd_word.dirty && dirty_in != '0) begin
         dirty_in = dirty_in - DW'(1);
      end

      if (csr_wr_en) begin
         pool_in = csr_wr_data;
         fill_in = (fill_ff < n_new) ? fill_ff : n_new;
         if (sweeping) begin
            lo_in = (lo_ff < n_new) ? lo_ff : n_new;
         end else begin
            lo_in  = n_new;
            rem_in = fill_ff;
         end
      end

      // hold the waiting result until a new one is issued
      if (!emit) begin
         rsp_in = rsp_ff;
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         shift_ff      <= 1'b0;
         dv_ff         <= 1'b0;
         dirty_ff      <= '0;
         fill_ff       <= '0;
         pool_ff       <= lpbt_pkg::POOL_RESET;
         rem_ff        <= '0;
         lo_ff         <= '0;
         sw_dv_ff      <= 1'b0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         shift_ff      <= shift_in;
         dv_ff         <= dv_in;
         dirty_ff      <= dirty_in;
         fill_ff       <= fill_in;
         pool_ff       <= pool_in;
         rem_ff        <= rem_in;
         lo_ff         <= lo_in;
         sw_dv_ff      <= sw_dv_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      page_ff         <= page_in;
      bad_ff          <= bad_in;
      rp_ff           <= rp_in;
      di_ff           <= di_in;
      carry_ff        <= carry_in;
      front_dirty_ff  <= front_dirty_in;
      front_wb_ff     <= front_wb_in;
      front_status_ff <= front_status_in;
      pend_page_ff    <= pend_page_in;
      pend_dirty_ff   <= pend_dirty_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_writeback   = rsp_ff.writeback;
   assign rsp_wb_page     = rsp_ff.wb_page;
   assign rsp_full_res    = rsp_ff.full_res;
   assign rsp_dirty_count = rsp_ff.dirty_count;
   assign rsp_last        = rsp_ff.last;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= n_act)
      else $error("fill count exceeds active pool size");

   a_dirty_bound: assert property (@(posedge clock) disable iff (reset)
      !sweeping |-> MW'(dirty_ff) <= MW'(fill_ff))
      else $error("dirty count exceeds filled slots");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && dv_ff) |-> CW'(di_ff) < fill_ff)
      else $error("list walk read beyond filled slots");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> fill_ff != '0)
      else $error("list walk started on an empty list");

endmodule

@@ rtl/lpbt_ram.sv @@
`timescale 1ns / 1ps
module lpbt_ram #(
   parameter int WIDTH = lpbt_pkg::WORD_W,
   parameter int DEPTH = lpbt_pkg::POOL_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/lru_page_buffer_tracker_tb.sv @@
`timescale 1ns / 1ps
module lru_page_buffer_tracker_tb;

   localparam int POOL_SLOTS   = lpbt_pkg::POOL_SLOTS_DEF;
   localparam int KIND_W       = lpbt_pkg::KIND_W;
   localparam int PAGE_W       = lpbt_pkg::PAGE_W;
   localparam int STATUS_W     = lpbt_pkg::STATUS_W;
   localparam int DCNT_W       = lpbt_pkg::DCNT_W;
   localparam int CFG_W        = lpbt_pkg::CFG_W;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE_TICKS = 64;
   localparam int HOLD_TICKS   = 300;
   localparam int HOLD_AT      = 40;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [PAGE_W-1:0] page;
   } page_req_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind        = lpbt_pkg::KIND_READ;
   logic [PAGE_W-1:0]   req_page_id     = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_writeback;
   logic [PAGE_W-1:0]   rsp_wb_page;
   logic                rsp_full_res;
   logic [DCNT_W-1:0]   rsp_dirty_count;
   logic                rsp_last;
   logic                csr_wr_en       = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data     = '0;

   // shadow of the buffer pool
   logic [PAGE_W-1:0] page_list [POOL_SLOTS];
   logic              page_dirty [POOL_SLOTS];
   int                dirty_pages;
   logic [CFG_W-1:0]  pool_size;

   page_req_type      page_requests[$];
   lpbt_pkg::rsp_type due_results[$];
   page_req_type      next_req;
   lpbt_pkg::rsp_type want;

   int  items_queued    = 0;
   int  items_accepted  = 0;
   int  results_checked = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   int  stall_ticks     = 0;
   int  send_idle_pct   = 0;
   int  recv_idle_pct   = 0;
   bit  failed          = 1'b0;

   lru_page_buffer_tracker i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_page_id     (req_page_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_writeback   (rsp_writeback),
      .rsp_wb_page     (rsp_wb_page),
      .rsp_full_res    (rsp_full_res),
      .rsp_dirty_count (rsp_dirty_count),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int active_slots();
      int n;
      n = int'(pool_size);
      if (n < 1) n = 1;
      if (n > POOL_SLOTS) n = POOL_SLOTS;
      return n;
   endfunction

   function automatic bit pool_full();
      for (int i = 0; i < active_slots(); i++)
         if (page_list[i] == '0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int find_slot(logic [PAGE_W-1:0] page);
      for (int i = 0; i < active_slots(); i++)
         if (page_list[i] == page) return i;
      return -1;
   endfunction

   function automatic void move_to_front(int from, logic [PAGE_W-1:0] page, logic dirty);
      for (int j = from; j > 0; j--) begin
         page_list[j]  = page_list[j-1];
         page_dirty[j] = page_dirty[j-1];
      end
      page_list[0]  = page;
      page_dirty[0] = dirty;
   endfunction

   // fullness is taken after the state update, as the block reports it
   function automatic lpbt_pkg::rsp_type page_result(logic [STATUS_W-1:0] status, logic wb,
                                                     logic [PAGE_W-1:0] wbp, logic last);
      lpbt_pkg::rsp_type r;
      r.status      = status;
      r.writeback   = wb;
      r.wb_page     = wbp;
      r.full_res    = pool_full();
      r.dirty_count = DCNT_W'(dirty_pages);
      r.last        = last;
      return r;
   endfunction

   function automatic void track_page_request(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page);
      int                n;
      int                idx;
      int                flushed;
      lpbt_pkg::rsp_type r;
      logic [PAGE_W-1:0] tail;
      n = active_slots();
      if (kind == lpbt_pkg::KIND_FLUSH_ALL) begin
         flushed = 0;
         for (int i = 0; i < n && page_list[i] != '0; i++) begin
            if (page_dirty[i] && flushed < lpbt_pkg::MAX_RESULTS) begin
               page_dirty[i] = 1'b0;
               if (dirty_pages > 0) dirty_pages--;
               due_results.push_back(page_result(lpbt_pkg::STS_HIT, 1'b1, page_list[i],
                                                 1'b0));
               flushed++;
            end
         end
         if (flushed == 0) begin
            due_results.push_back(page_result(lpbt_pkg::STS_NOT_DIRTY, 1'b0, '0, 1'b1));
         end else begin
            r = due_results.pop_back();
            r.last = 1'b1;
            due_results.push_back(r);
         end
         return;
      end
      if (page == '0) begin
         due_results.push_back(page_result(lpbt_pkg::STS_BAD_ID, 1'b0, '0, 1'b1));
         return;
      end
      idx = find_slot(page);
      if (kind == lpbt_pkg::KIND_READ) begin
         if (idx >= 0) begin
            move_to_front(idx, page, page_dirty[idx]);
            due_results.push_back(page_result(lpbt_pkg::STS_HIT, 1'b0, '0, 1'b1));
         end else begin
            tail = page_list[n-1];
            if (tail != '0 && page_dirty[n-1]) begin
               if (dirty_pages > 0) dirty_pages--;
               move_to_front(n - 1, page, 1'b0);
               due_results.push_back(page_result(lpbt_pkg::STS_INSERTED, 1'b1, tail, 1'b1));
            end else begin
               move_to_front(n - 1, page, 1'b0);
               due_results.push_back(page_result(lpbt_pkg::STS_INSERTED, 1'b0, '0, 1'b1));
            end
         end
      end else if (idx < 0) begin
         due_results.push_back(page_result(lpbt_pkg::STS_ABSENT, 1'b0, '0, 1'b1));
      end else if (kind == lpbt_pkg::KIND_MARK) begin
         if (page_dirty[idx]) begin
            due_results.push_back(page_result(lpbt_pkg::STS_DIRTY, 1'b0, '0, 1'b1));
         end else begin
            dirty_pages++;
            move_to_front(idx, page, 1'b1);
            due_results.push_back(page_result(lpbt_pkg::STS_HIT, 1'b0, '0, 1'b1));
         end
      end else if (!page_dirty[idx]) begin
         due_results.push_back(page_result(lpbt_pkg::STS_NOT_DIRTY, 1'b0, '0, 1'b1));
      end else begin
         page_dirty[idx] = 1'b0;
         if (dirty_pages > 0) dirty_pages--;
         due_results.push_back(page_result(lpbt_pkg::STS_HIT, 1'b1, page, 1'b1));
      end
   endfunction

   // a shrink drops the slots past the new size, dirty ones without write-back
   function automatic void resize_pool(logic [CFG_W-1:0] value);
      pool_size = value;
      for (int i = active_slots(); i < POOL_SLOTS; i++) begin
         if (page_list[i] != '0 && page_dirty[i] && dirty_pages > 0) dirty_pages--;
         page_list[i]  = '0;
         page_dirty[i] = 1'b0;
      end
   endfunction

   function automatic void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
         failed = 1'b1;
      end
   endfunction

   task automatic queue_req(logic [KIND_W-1:0] kind, logic [PAGE_W-1:0] page);
      page_req_type r;
      r.kind = kind;
      r.page = page;
      page_requests.push_back(r);
      items_queued++;
   endtask

   // mostly a small set of hot pages so reads hit and marks find their page
   task automatic queue_random(int count, int hot_span);
      int                k;
      int                p;
      logic [KIND_W-1:0] kind;
      logic [PAGE_W-1:0] page;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         p = $urandom_range(99);
         if (k < 45) kind = lpbt_pkg::KIND_READ;
         else if (k < 70) kind = lpbt_pkg::KIND_MARK;
         else if (k < 88) kind = lpbt_pkg::KIND_FLUSH;
         else kind = lpbt_pkg::KIND_FLUSH_ALL;
         if (p < 5) page = '0;
         else if (p < 20) page = PAGE_W'($urandom);
         else page = PAGE_W'($urandom_range(hot_span, 1));
         queue_req(kind, page);
      end
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || due_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      resize_pool(value);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_page_request(req_kind, req_page_id);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (page_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = page_requests.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= next_req.kind;
               req_page_id <= next_req.page;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, status %0d wb_page %0d", $time,
                        rsp_status, rsp_wb_page);
               failed = 1'b1;
            end else begin
               want = due_results.pop_front();
               compare_field("status", want.status, rsp_status);
               compare_field("writeback", want.writeback, rsp_writeback);
               compare_field("wb_page", want.wb_page, rsp_wb_page);
               compare_field("full_res", want.full_res, rsp_full_res);
               compare_field("dirty_count", want.dirty_count, rsp_dirty_count);
               compare_field("last", want.last, rsp_last);
            end
            results_checked++;
            // hold off once for a long stretch so the block backs up its input
            if (results_checked == HOLD_AT && !hold_done) begin
               hold_done = 1'b1;
               hold_left = HOLD_TICKS;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_ticks = 0;
      end else begin
         stall_ticks++;
         if (stall_ticks >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
         page_list[i]  = '0;
         page_dirty[i] = 1'b0;
      end
      dirty_pages = 0;
      pool_size   = lpbt_pkg::POOL_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 82;
      // two slots make eviction easy to reach
      write_pool_size(CFG_W'(2));
      queue_req(lpbt_pkg::KIND_READ, '0);
      queue_req(lpbt_pkg::KIND_MARK, '0);
      queue_req(lpbt_pkg::KIND_FLUSH, '0);
      queue_req(lpbt_pkg::KIND_FLUSH_ALL, '0);
      queue_req(lpbt_pkg::KIND_MARK, 16'h0001);
      queue_req(lpbt_pkg::KIND_FLUSH, 16'h0001);
      queue_req(lpbt_pkg::KIND_READ, 16'hFFFF);
      queue_req(lpbt_pkg::KIND_READ, 16'h0001);
      queue_req(lpbt_pkg::KIND_READ, 16'hFFFF);
      queue_req(lpbt_pkg::KIND_MARK, 16'hFFFF);
      queue_req(lpbt_pkg::KIND_MARK, 16'hFFFF);
      queue_req(lpbt_pkg::KIND_FLUSH, 16'h0001);
      queue_req(lpbt_pkg::KIND_READ, 16'h8000);
      queue_req(lpbt_pkg::KIND_MARK, 16'h8000);
      queue_req(lpbt_pkg::KIND_READ, 16'h7FFF);
      queue_req(lpbt_pkg::KIND_MARK, 16'h7FFF);
      queue_req(lpbt_pkg::KIND_FLUSH_ALL, 16'hFFFF);
      queue_req(lpbt_pkg::KIND_FLUSH_ALL, '0);
      queue_req(lpbt_pkg::KIND_MARK, 16'h8000);
      queue_req(lpbt_pkg::KIND_FLUSH, 16'h8000);
      queue_req(lpbt_pkg::KIND_READ, 16'h5555);
      queue_req(lpbt_pkg::KIND_MARK, 16'h5555);
      queue_req(lpbt_pkg::KIND_READ, 16'hAAAA);
      wait_drained();

      write_pool_size(CFG_W'(31));
      queue_random(150, 22);
      wait_drained();

      send_idle_pct = 82;
      recv_idle_pct = 7;
      write_pool_size(CFG_W'(5));
      queue_random(150, 8);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_pool_size(CFG_W'(0));
      queue_random(50, 3);
      wait_drained();

      write_pool_size(CFG_W'(16));
      queue_random(100, 20);
      wait_drained();

      if (!failed && due_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
